[sv/tlau_pkg.sv]
// Shared types and constants for the toroidal life automaton unit.
`timescale 1ns / 1ps

package tlau_pkg;

    // Width of one grid row as stored and reported.
    localparam int ROW_W = 64;

    // Widths of the request and result fields.
    localparam int IDX_W = 6;
    localparam int CFG_W = 7;

    // Request kinds carried on the input tuser.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_ACTIVE_ROWS = 1'b0;
    localparam logic CFG_ACTIVE_COLS = 1'b1;

    // Control for one row cell of the rotating chain.
    typedef struct packed {
        logic shift;  // take a new row this cycle
        logic tail;   // last active cell: take the fed-back row, not the neighbour's
    } cell_ctrl_t;

endpackage

[sv/tlau_cell.sv]
// One row cell of the rotating grid chain.
`timescale 1ns / 1ps

module tlau_cell
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  tlau_pkg::cell_ctrl_t          ctrl,
    input  logic [tlau_pkg::ROW_W-1:0]    nbr_row,
    input  logic [tlau_pkg::ROW_W-1:0]    fb_row,
    output logic [tlau_pkg::ROW_W-1:0]    row_q
);

    logic [tlau_pkg::ROW_W-1:0] row_reg;
    logic [tlau_pkg::ROW_W-1:0] row_next;

    // The tail cell closes the ring with the row handed back by the control.
    assign row_next = ctrl.tail ? fb_row : nbr_row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
        end
        else if (ctrl.shift)
        begin
            row_reg <= row_next;
        end
    end

    assign row_q = row_reg;

endmodule

[sv/tlau_rule.sv]
// B3/S23 next-generation logic for one row, with wrap at the active column count.
`timescale 1ns / 1ps

module tlau_rule
(
    input  logic [tlau_pkg::ROW_W-1:0]    above,
    input  logic [tlau_pkg::ROW_W-1:0]    cur,
    input  logic [tlau_pkg::ROW_W-1:0]    below,
    input  logic [tlau_pkg::CFG_W-1:0]    ncols,
    output logic [tlau_pkg::ROW_W-1:0]    next_row
);

    logic [tlau_pkg::CFG_W-1:0] ncols_m1;
    logic [tlau_pkg::IDX_W-1:0] wrap_idx;

    assign ncols_m1 = ncols - 7'd1;
    assign wrap_idx = ncols_m1[tlau_pkg::IDX_W-1:0];

    for (genvar c = 0; c < tlau_pkg::ROW_W; c++)
    begin : g_col
        logic [tlau_pkg::IDX_W-1:0] left_idx;
        logic [tlau_pkg::IDX_W-1:0] right_idx;
        logic [3:0]                 count;

        // The left neighbour of column zero is the last active column, and the
        // right neighbour of the last active column is column zero.
        assign left_idx  = (c == 0) ? wrap_idx : tlau_pkg::IDX_W'(c - 1);
        assign right_idx = (ncols_m1 == tlau_pkg::CFG_W'(c)) ? '0
                         : tlau_pkg::IDX_W'((c + 1) % tlau_pkg::ROW_W);

        assign count = 4'(above[left_idx]) + 4'(above[c]) + 4'(above[right_idx])
                     + 4'(cur[left_idx])                  + 4'(cur[right_idx])
                     + 4'(below[left_idx]) + 4'(below[c]) + 4'(below[right_idx]);

        assign next_row[c] = (count == 4'd3) || (cur[c] && (count == 4'd2));
    end

endmodule

[sv/toroidal_life_automaton_unit.sv]
// Operation: a write request walks the ring of active rows once; its result is registered
// as the target row passes the head, or, for a row outside the active area, without a walk.
// A step request yields one new row per cycle while the output is not stalled, from row 0
// on through the active rows of the ring. A new request is taken only once the unit is idle,
// that is after the previous request has finished its walk of the ring.
// Reset: every cell dead, both active counts 64, no result pending.
`timescale 1ns / 1ps

module toroidal_life_automaton_unit
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,

    // Configuration write port.
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data,

    // Request stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // row [5:0], col [11:6], alive [12], zero [15:13]
    input  logic        s_axis_tuser,   // op

    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // row_index [5:0], row_bits [69:6], zero [71:70]
    output logic        m_axis_tlast    // last
);

    // Only the first 64 rows can ever be active, so the chain holds at most 64 cells.
    localparam int ROW_CELLS = (MAX_ROWS < 64) ? MAX_ROWS : 64;
    localparam int RIDX_W    = $clog2(ROW_CELLS);
    localparam logic [6:0] ROW_LIM = 7'(ROW_CELLS);
    localparam logic [6:0] COL_LIM = 7'(MAX_COLS);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WRITE = 2'd1;
    localparam logic [1:0] ST_STEP  = 2'd2;

    localparam int W = tlau_pkg::ROW_W;

    // Configuration registers.
    logic [6:0] active_rows_reg;
    logic [6:0] active_cols_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_rows_reg <= 7'd64;
            active_cols_reg <= 7'd64;
        end
        else if (cfg_we)
        begin
            if (cfg_index == tlau_pkg::CFG_ACTIVE_ROWS)
            begin
                active_rows_reg <= cfg_data;
            end
            else
            begin
                active_cols_reg <= cfg_data;
            end
        end
    end

    // Effective counts: the registers saturated into the range the grid supports.
    logic [6:0]   nrows;
    logic [6:0]   ncols;
    logic [6:0]   nrows_m1;
    logic [W-1:0] col_mask;

    always_comb
    begin
        nrows = active_rows_reg;
        if (nrows == 7'd0)
        begin
            nrows = 7'd1;
        end
        else if (nrows > ROW_LIM)
        begin
            nrows = ROW_LIM;
        end
        ncols = active_cols_reg;
        if (ncols == 7'd0)
        begin
            ncols = 7'd1;
        end
        else if (ncols > COL_LIM)
        begin
            ncols = COL_LIM;
        end
    end

    assign nrows_m1 = nrows - 7'd1;

    for (genvar c = 0; c < W; c++)
    begin : g_mask
        assign col_mask[c] = (7'(c) < ncols);
    end

    // Control state.
    logic [1:0]   state_reg,  state_next;
    logic [5:0]   cnt_reg,    cnt_next;
    logic [5:0]   wr_row_reg, wr_row_next;
    logic [5:0]   wr_col_reg, wr_col_next;
    logic         wr_val_reg, wr_val_next;
    logic [W-1:0] prev_reg,   prev_next;
    logic [W-1:0] first_reg,  first_next;

    // Result register.
    logic         out_valid_reg, out_valid_next;
    logic [5:0]   out_index_reg, out_index_next;
    logic [W-1:0] out_bits_reg,  out_bits_next;
    logic         out_last_reg,  out_last_next;

    // Row chain.
    logic [W-1:0]         cell_q   [ROW_CELLS];
    logic [W-1:0]         cell_nbr [ROW_CELLS];
    tlau_pkg::cell_ctrl_t cell_ctrl[ROW_CELLS];
    logic [W-1:0]         feedback;
    logic                 go;

    logic [W-1:0] head_row;
    logic [W-1:0] below_row;
    logic [W-1:0] gen_row;
    logic [W-1:0] wr_row_bits;
    logic [W-1:0] wr_bit;
    logic         at_tail;
    logic         wr_hit;
    logic         advance;
    logic         accept;

    assign head_row = cell_q[0];
    assign at_tail  = ({1'b0, cnt_reg} == nrows_m1);

    // The row below the last one wraps to the old row 0, kept aside at the start.
    assign below_row = at_tail ? first_reg : cell_q[1];

    tlau_rule u_rule
    (
        .above    (prev_reg),
        .cur      (head_row),
        .below    (below_row),
        .ncols    (ncols),
        .next_row (gen_row)
    );

    // Row under a write, with the cell changed only inside the active columns.
    assign wr_bit = W'(1) << wr_col_reg;

    always_comb
    begin
        wr_row_bits = head_row;
        if ({1'b0, wr_col_reg} < ncols)
        begin
            wr_row_bits = wr_val_reg ? (head_row | wr_bit) : (head_row & ~wr_bit);
        end
    end

    assign wr_hit  = (cnt_reg == wr_row_reg);
    assign advance = !out_valid_reg || m_axis_tready;
    assign accept  = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        wr_row_next    = wr_row_reg;
        wr_col_next    = wr_col_reg;
        wr_val_next    = wr_val_reg;
        prev_next      = prev_reg;
        first_next     = first_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_index_next = out_index_reg;
        out_bits_next  = out_bits_reg;
        out_last_next  = out_last_reg;
        feedback       = head_row;
        go             = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cnt_next = '0;
                    if (s_axis_tuser == tlau_pkg::OP_STEP)
                    begin
                        // The row above row 0 is the last active row.
                        first_next = cell_q[0];
                        prev_next  = cell_q[nrows_m1[RIDX_W-1:0]];
                        state_next = ST_STEP;
                    end
                    else
                    begin
                        wr_row_next = s_axis_tdata[5:0];
                        wr_col_next = s_axis_tdata[11:6];
                        wr_val_next = s_axis_tdata[12];
                        state_next  = ST_WRITE;
                    end
                end
            end

            ST_WRITE:
            begin
                if ({1'b0, wr_row_reg} >= nrows)
                begin
                    // Row outside the active area: the grid is left alone.
                    if (advance)
                    begin
                        out_valid_next = 1'b1;
                        out_index_next = wr_row_reg;
                        out_bits_next  = '0;
                        out_last_next  = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    // Rotate the whole ring once; the target row is changed as it
                    // passes the head and reported at that moment.
                    go = wr_hit ? advance : 1'b1;
                    if (wr_hit)
                    begin
                        feedback = wr_row_bits;
                    end
                    if (go)
                    begin
                        if (wr_hit)
                        begin
                            out_valid_next = 1'b1;
                            out_index_next = wr_row_reg;
                            out_bits_next  = wr_row_bits & col_mask;
                            out_last_next  = 1'b1;
                        end
                        cnt_next = cnt_reg + 6'd1;
                        if (at_tail)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end

            ST_STEP:
            begin
                // Inactive columns keep their old contents.
                feedback = (gen_row & col_mask) | (head_row & ~col_mask);
                go       = advance;
                if (advance)
                begin
                    out_valid_next = 1'b1;
                    out_index_next = cnt_reg;
                    out_bits_next  = gen_row & col_mask;
                    out_last_next  = at_tail;
                    prev_next      = head_row;
                    cnt_next       = cnt_reg + 6'd1;
                    if (at_tail)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_row_reg    <= wr_row_next;
        wr_col_reg    <= wr_col_next;
        wr_val_reg    <= wr_val_next;
        prev_reg      <= prev_next;
        first_reg     <= first_next;
        out_index_reg <= out_index_next;
        out_bits_reg  <= out_bits_next;
        out_last_reg  <= out_last_next;
    end

    // Ring of row cells: each active cell takes its upper neighbour's row, and the
    // last active cell takes the row handed back from the head.
    for (genvar k = 0; k < ROW_CELLS; k++)
    begin : g_cell
        if (k == ROW_CELLS - 1)
        begin : g_end
            assign cell_nbr[k] = feedback;
        end
        else
        begin : g_mid
            assign cell_nbr[k] = cell_q[k + 1];
        end

        assign cell_ctrl[k].shift = go && (7'(k) < nrows);
        assign cell_ctrl[k].tail  = (7'(k) == nrows_m1);

        tlau_cell u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (cell_ctrl[k]),
            .nbr_row (cell_nbr[k]),
            .fb_row  (feedback),
            .row_q   (cell_q[k])
        );
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_bits_reg, out_index_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

[bench/toroidal_life_automaton_unit_checker.sv]
// Checker for the life automaton unit: predicts every reported row and compares it.
`timescale 1ns / 1ps

module toroidal_life_automaton_unit_checker
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // row [5:0], col [11:6], alive [12], zero [15:13]
    input  logic        s_axis_tuser,   // op
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [71:0] m_axis_tdata,   // row_index [5:0], row_bits [69:6], zero [71:70]
    input  logic        m_axis_tlast,   // last
    output int          mismatches,
    output int          outstanding
);

    localparam int GRID_DEPTH = 64;
    localparam int ROW_LIMIT  = (MAX_ROWS < 64) ? MAX_ROWS : 64;

    typedef struct packed {
        logic [tlau_pkg::IDX_W-1:0] row_index;
        logic [tlau_pkg::ROW_W-1:0] row_bits;
        logic                       last;
    } row_report_t;

    logic [tlau_pkg::ROW_W-1:0] life_grid [GRID_DEPTH];
    logic [tlau_pkg::CFG_W-1:0] rows_setting;
    logic [tlau_pkg::CFG_W-1:0] cols_setting;
    row_report_t                pending_rows [$];

    function automatic int clamp_extent(input logic [tlau_pkg::CFG_W-1:0] value,
                                        input int limit);
        if (value == 0)
            return 1;
        if (value > limit)
            return limit;
        return int'(value);
    endfunction

    function automatic logic [tlau_pkg::ROW_W-1:0] column_mask(input int n_cols);
        if (n_cols >= tlau_pkg::ROW_W)
            return '1;
        return (64'd1 << n_cols) - 64'd1;
    endfunction

    // A write changes the cell only inside the active area, but always reports its row.
    task automatic apply_cell_write(input logic [5:0] r, input logic [5:0] c, input logic alive);
        int          n_rows;
        int          n_cols;
        row_report_t report;
        n_rows = clamp_extent(rows_setting, ROW_LIMIT);
        n_cols = clamp_extent(cols_setting, MAX_COLS);
        report.row_index = r;
        report.row_bits  = '0;
        report.last      = 1'b1;
        if (r < n_rows)
        begin
            if (c < n_cols)
                life_grid[r][c] = alive;
            report.row_bits = life_grid[r] & column_mask(n_cols);
        end
        pending_rows.push_back(report);
    endtask

    // B3/S23 on the wrapped active area; cells beyond it are left as they are.
    task automatic advance_generation();
        int                         n_rows;
        int                         n_cols;
        int                         count;
        int                         rr;
        int                         cc;
        logic [tlau_pkg::ROW_W-1:0] mask;
        logic [tlau_pkg::ROW_W-1:0] next_rows [GRID_DEPTH];
        row_report_t                report;
        n_rows = clamp_extent(rows_setting, ROW_LIMIT);
        n_cols = clamp_extent(cols_setting, MAX_COLS);
        mask   = column_mask(n_cols);
        for (int r = 0; r < n_rows; r++)
        begin
            next_rows[r] = '0;
            for (int c = 0; c < n_cols; c++)
            begin
                count = 0;
                for (int dr = 0; dr < 3; dr++)
                begin
                    rr = (r + n_rows + dr - 1) % n_rows;
                    for (int dc = 0; dc < 3; dc++)
                    begin
                        if (dr != 1 || dc != 1)
                        begin
                            cc = (c + n_cols + dc - 1) % n_cols;
                            count += life_grid[rr][cc];
                        end
                    end
                end
                if (life_grid[r][c])
                    next_rows[r][c] = (count == 2) || (count == 3);
                else
                    next_rows[r][c] = (count == 3);
            end
        end
        for (int r = 0; r < n_rows; r++)
        begin
            life_grid[r] = (next_rows[r] & mask) | (life_grid[r] & ~mask);
            report.row_index = tlau_pkg::IDX_W'(r);
            report.row_bits  = life_grid[r] & mask;
            report.last      = (r + 1 == n_rows);
            pending_rows.push_back(report);
        end
    endtask

    task automatic check_row_report();
        row_report_t seen;
        row_report_t want;
        seen.row_index = m_axis_tdata[tlau_pkg::IDX_W-1:0];
        seen.row_bits  = m_axis_tdata[tlau_pkg::IDX_W+tlau_pkg::ROW_W-1:tlau_pkg::IDX_W];
        seen.last      = m_axis_tlast;
        if (pending_rows.size() == 0)
        begin
            if (mismatches < 10)
                $display("unexpected row report: row_index %0d row_bits %h last %b",
                         seen.row_index, seen.row_bits, seen.last);
            mismatches++;
        end
        else
        begin
            want = pending_rows.pop_front();
            if (seen != want)
            begin
                if (mismatches < 10)
                    $display("mismatch: exp row %0d bits %h last %b, got row %0d bits %h last %b",
                             want.row_index, want.row_bits, want.last,
                             seen.row_index, seen.row_bits, seen.last);
                mismatches++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < GRID_DEPTH; r++)
                life_grid[r] = '0;
            rows_setting = tlau_pkg::CFG_W'(64);
            cols_setting = tlau_pkg::CFG_W'(64);
            pending_rows.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == tlau_pkg::CFG_ACTIVE_ROWS)
                    rows_setting = cfg_data;
                else
                    cols_setting = cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser == tlau_pkg::OP_STEP)
                    advance_generation();
                else
                    apply_cell_write(s_axis_tdata[5:0], s_axis_tdata[11:6], s_axis_tdata[12]);
            end
            if (m_axis_tvalid && m_axis_tready)
                check_row_report();
            outstanding = pending_rows.size();
        end
    end

endmodule

[bench/toroidal_life_automaton_unit_tb.sv]
// Testbench top for the life automaton unit: drives requests and configuration, gives the verdict.
`timescale 1ns / 1ps

module toroidal_life_automaton_unit_tb;

    // A step of the full 64-row grid is the longest busy stretch of the unit; the quiet limit
    // covers the long receiver hold-off and the pauses between phases many times over.
    localparam int QUIET_LIMIT   = 5000;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 140;
    localparam int RANDOM_ITEMS  = 230;

    typedef enum int {
        FLOW_STEADY,
        FLOW_SENDER_GAPS,
        FLOW_RECEIVER_STALLS,
        FLOW_BOTH_IDLE
    } flow_mode_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [6:0]  cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // row [5:0], col [11:6], alive [12], zero [15:13]
    logic        s_axis_tuser;   // op
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;   // row_index [5:0], row_bits [69:6], zero [71:70]
    logic        m_axis_tlast;   // last

    int          mismatches;
    int          outstanding;

    // Percentages of cycles in which the sender stays idle and the receiver stalls.
    int          send_idle_pct;
    int          recv_stall_pct;
    // Raised by the stimulus to ask the receiver for one long hold-off.
    bit          hold_request;
    int          quiet_cycles;

    // Shape of the current random phase: the effective grid size and the corner of the patch
    // into which most cell writes are packed, so that generations have something to chew on.
    int          random_sent;
    int          n_rows;
    int          n_cols;
    int          base_r;
    int          base_c;

    toroidal_life_automaton_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    toroidal_life_automaton_unit_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // The receiver decides its ready afresh at every rising edge. When a long hold-off is asked
    // for, it keeps ready low for a fixed count of its own cycles while the sender carries on,
    // so that the unit's output backs up and it has to refuse further requests.
    initial
    begin
        m_axis_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog: a run in which nothing moves on either side for too long has hung.
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic set_flow(input flow_mode_t mode);
        case (mode)
            FLOW_STEADY:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            FLOW_SENDER_GAPS:
            begin
                send_idle_pct  = 60;
                recv_stall_pct = 0;
            end
            FLOW_RECEIVER_STALLS:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 60;
            end
            default:
            begin
                send_idle_pct  = 37;
                recv_stall_pct = 37;
            end
        endcase
    endtask

    // Offers one request and returns in the time step of the edge that accepted it. Inputs
    // are read straight after the edge, before any update made at that edge has landed.
    task automatic send_request(input logic op, input logic [5:0] r, input logic [5:0] c,
                                input logic alive);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, alive, c, r};
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    // Lets every expected row come back, then gives the unit time to finish its ring walk, so
    // that a following register write lands on an idle unit. Counts are read at falling edges,
    // well clear of the checker's updates.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic index, input logic [6:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    function automatic int effective_extent(input logic [6:0] value);
        if (value == 0)
            return 1;
        if (value > 64)
            return 64;
        return int'(value);
    endfunction

    // Mostly dense writes into a small patch that wraps round the active edges, some anywhere
    // in the active area, and a few fully random ones that often fall outside it.
    task automatic scatter_write();
        int         pick;
        logic [5:0] r;
        logic [5:0] c;
        logic       alive;
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            r     = 6'((base_r + $urandom_range(0, 4)) % n_rows);
            c     = 6'((base_c + $urandom_range(0, 4)) % n_cols);
            alive = ($urandom_range(0, 99) < 80);
        end
        else if (pick < 85)
        begin
            r     = 6'($urandom_range(0, n_rows - 1));
            c     = 6'($urandom_range(0, n_cols - 1));
            alive = 1'($urandom);
        end
        else
        begin
            r     = 6'($urandom);
            c     = 6'($urandom);
            alive = 1'($urandom);
        end
        send_request(tlau_pkg::OP_WRITE, r, c, alive);
        random_sent++;
    endtask

    function automatic logic [6:0] pick_extent();
        case ($urandom_range(0, 9))
            0:       return 7'd1;
            1:       return 7'd64;
            2:       return 7'($urandom_range(65, 127));
            3:       return 7'd0;
            4:       return 7'd2;
            default: return 7'($urandom_range(3, 12));
        endcase
    endfunction

    initial
    begin
        int         phase;
        logic [6:0] rows_value;
        logic [6:0] cols_value;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = tlau_pkg::CFG_ACTIVE_ROWS;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = tlau_pkg::OP_WRITE;
        hold_request  = 1'b0;
        random_sent   = 0;
        set_flow(FLOW_STEADY);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, first on the full 64 by 64 grid left by reset. The four corners are
        // one another's wrapped neighbours; a cell is set and cleared again; a blinker turns.
        send_request(tlau_pkg::OP_WRITE, 6'd0, 6'd0, 1'b1);
        send_request(tlau_pkg::OP_WRITE, 6'd63, 6'd63, 1'b1);
        send_request(tlau_pkg::OP_WRITE, 6'd0, 6'd63, 1'b1);
        send_request(tlau_pkg::OP_WRITE, 6'd63, 6'd0, 1'b1);
        send_request(tlau_pkg::OP_WRITE, 6'd5, 6'd5, 1'b1);
        send_request(tlau_pkg::OP_WRITE, 6'd5, 6'd5, 1'b0);
        for (int c = 19; c <= 21; c++)
            send_request(tlau_pkg::OP_WRITE, 6'd10, 6'(c), 1'b1);
        // The fields that a step ignores are set to all ones here.
        repeat (2) send_request(tlau_pkg::OP_STEP, 6'd63, 6'd63, 1'b1);

        // A 3 by 3 grid, with writes whose row or whose column lies outside the active area.
        settle();
        write_config(tlau_pkg::CFG_ACTIVE_ROWS, 7'd3);
        write_config(tlau_pkg::CFG_ACTIVE_COLS, 7'd3);
        send_request(tlau_pkg::OP_WRITE, 6'd1, 6'd1, 1'b1);
        send_request(tlau_pkg::OP_WRITE, 6'd0, 6'd1, 1'b1);
        send_request(tlau_pkg::OP_STEP, 6'd0, 6'd0, 1'b0);
        send_request(tlau_pkg::OP_WRITE, 6'd7, 6'd1, 1'b1);
        send_request(tlau_pkg::OP_WRITE, 6'd1, 6'd9, 1'b1);

        // A single cell is its own neighbour eight times over.
        settle();
        write_config(tlau_pkg::CFG_ACTIVE_ROWS, 7'd1);
        write_config(tlau_pkg::CFG_ACTIVE_COLS, 7'd1);
        send_request(tlau_pkg::OP_WRITE, 6'd0, 6'd0, 1'b1);
        send_request(tlau_pkg::OP_STEP, 6'd0, 6'd0, 1'b0);

        // A 2 by 2 grid, where every neighbour position is filled twice.
        settle();
        write_config(tlau_pkg::CFG_ACTIVE_ROWS, 7'd2);
        write_config(tlau_pkg::CFG_ACTIVE_COLS, 7'd2);
        send_request(tlau_pkg::OP_STEP, 6'd21, 6'd42, 1'b0);

        // Register values out of range saturate: zero to one, anything above 64 to 64.
        settle();
        write_config(tlau_pkg::CFG_ACTIVE_ROWS, 7'd0);
        write_config(tlau_pkg::CFG_ACTIVE_COLS, 7'd127);
        send_request(tlau_pkg::OP_WRITE, 6'd0, 6'd63, 1'b1);
        send_request(tlau_pkg::OP_STEP, 6'd42, 6'd21, 1'b1);
        settle();
        write_config(tlau_pkg::CFG_ACTIVE_ROWS, 7'd127);
        write_config(tlau_pkg::CFG_ACTIVE_COLS, 7'd0);
        send_request(tlau_pkg::OP_STEP, 6'd0, 6'd63, 1'b0);
        send_request(tlau_pkg::OP_WRITE, 6'd63, 6'd0, 1'b0);

        // Random part: each phase picks a grid size and an idling pattern, seeds a patch of
        // cells and then runs a few generations with stray writes in between. Every third
        // phase uses the full grid so that long steps meet every idling pattern.
        phase = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            settle();
            if (phase % 3 == 2)
            begin
                rows_value = 7'd64;
                cols_value = 7'd64;
            end
            else
            begin
                rows_value = pick_extent();
                cols_value = pick_extent();
            end
            write_config(tlau_pkg::CFG_ACTIVE_ROWS, rows_value);
            write_config(tlau_pkg::CFG_ACTIVE_COLS, cols_value);
            n_rows = effective_extent(rows_value);
            n_cols = effective_extent(cols_value);
            base_r = $urandom_range(0, n_rows - 1);
            base_c = $urandom_range(0, n_cols - 1);
            set_flow(flow_mode_t'(phase % 4));
            // Once, on a full grid, the receiver holds off while requests keep coming.
            if (phase == 2)
                hold_request = 1'b1;
            repeat ($urandom_range(12, 20)) scatter_write();
            repeat ($urandom_range(2, 4))
            begin
                send_request(tlau_pkg::OP_STEP, 6'($urandom), 6'($urandom), 1'($urandom));
                random_sent++;
                repeat ($urandom_range(0, 3)) scatter_write();
            end
            phase++;
        end

        settle();
        @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
